FILE: hw/rtl/rcfd_pkg.sv
// Shared types, constants and helper functions of the RC link frame decoder.
package rcfd_pkg;

    // Parameter defaults
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int MAX_FRAME_DEF    = 64;

    // Frame layout
    localparam int PAYLOAD_BYTES = 22;
    localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
    localparam int CHAN_BITS     = 11;
    localparam int CHAN_IDX_W    = 4;
    localparam int PULSE_W       = 12;
    localparam logic [7:0] GOOD_FRAME_SIZE = 8'(PAYLOAD_BYTES + 4);

    // CRC-8, polynomial 0xD5, no reflection
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // Pulse conversion: ((v - CENTER) * 5) / 8 + MID
    localparam int PULSE_CENTER = 992;
    localparam int PULSE_MID    = 1500;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE  = 2'd2;
    localparam logic [7:0]           FRAME_TYPE_RST = 8'h16;
    localparam logic [PULSE_W-1:0]   MIN_PULSE_RST  = 12'd988;
    localparam logic [PULSE_W-1:0]   MAX_PULSE_RST  = 12'd2012;

    // Hand-off of a good frame from the byte parser to the channel emitter
    typedef struct packed {
        logic                    valid;
        logic [PAYLOAD_BITS-1:0] payload;
    } frame_load_t;

    // One byte step of the CRC-8
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/rcfd_frame_rx.sv
// Byte parser of the RC link frame decoder: framing, CRC check and payload capture.
module rcfd_frame_rx #(
    parameter int MAX_FRAME = rcfd_pkg::MAX_FRAME_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic [7:0]           frame_type,
    input  logic                 emit_busy,
    output rcfd_pkg::frame_load_t frame_load
);
    import rcfd_pkg::*;

    localparam logic [7:0] LEN_MIN = 8'd2;
    localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME - 2);

    logic [7:0]              pos_reg, pos_next;
    logic [7:0]              size_reg, size_next;
    logic [7:0]              kind_reg, kind_next;
    logic [7:0]              crc_reg, crc_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;

    logic accept;
    logic in_body;
    logic at_crc;
    logic frame_ok;

    // Classify the current position in the frame
    assign in_body = (pos_reg >= 8'd2) && (({1'b0, pos_reg} + 9'd1) < {1'b0, size_reg});
    assign at_crc  = (pos_reg >= 8'd2) && !in_body;

    // Hold the final word of a frame while the emitter still drains the previous one
    assign s_tready = !(at_crc && emit_busy);
    assign accept   = s_tvalid && s_tready;

    assign frame_ok = (s_tdata == crc_reg) && (kind_reg == frame_type)
                   && (size_reg == GOOD_FRAME_SIZE);

    // Advance the frame parser on each accepted word
    always_comb begin
        pos_next     = pos_reg;
        size_next    = size_reg;
        kind_next    = kind_reg;
        crc_next     = crc_reg;
        payload_next = payload_reg;
        frame_load.valid   = 1'b0;
        frame_load.payload = payload_reg;
        if (accept) begin
            if (pos_reg == 8'd0) begin
                pos_next  = 8'd1;
                size_next = 8'd0;
            end else if (pos_reg == 8'd1) begin
                if (s_tdata < LEN_MIN || s_tdata > LEN_MAX) begin
                    pos_next = 8'd0;
                end else begin
                    size_next = s_tdata + 8'd2;
                    crc_next  = 8'd0;
                    pos_next  = 8'd2;
                end
            end else if (in_body) begin
                if (pos_reg == 8'd2) begin
                    kind_next = s_tdata;
                end else begin
                    // first payload byte ends up in the lowest bits
                    payload_next = {s_tdata, payload_reg[PAYLOAD_BITS-1:8]};
                end
                crc_next = crc8_update(crc_reg, s_tdata);
                pos_next = pos_reg + 8'd1;
            end else begin
                pos_next         = 8'd0;
                size_next        = 8'd0;
                frame_load.valid = frame_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 8'd0;
            size_reg <= 8'd0;
            kind_reg <= 8'd0;
            crc_reg  <= 8'd0;
        end else begin
            pos_reg  <= pos_next;
            size_reg <= size_next;
            kind_reg <= kind_next;
            crc_reg  <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
    end

`ifndef NO_ASSERTIONS
    // A frame is handed over only on an accepted final word
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_load.valid |-> (accept && at_crc && !emit_busy))
        else $error("frame load outside final word");

    // The parser never runs past the announced frame size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg >= 8'd2) |-> (pos_reg < size_reg))
        else $error("byte position beyond frame size");

    // An accepted final word always returns the parser to the address byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && at_crc) |=> (pos_reg == 8'd0))
        else $error("parser did not return to idle");
`endif

endmodule

FILE: hw/rtl/rcfd_chan_emit.sv
// Channel emitter of the RC link frame decoder: unpack, convert and saturate per channel.
module rcfd_chan_emit #(
    parameter int NUM_CHANNELS = rcfd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rcfd_pkg::frame_load_t         frame_load,
    input  logic [rcfd_pkg::PULSE_W-1:0]  min_pulse_us,
    input  logic [rcfd_pkg::PULSE_W-1:0]  max_pulse_us,
    output logic                          emit_busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic                          m_tlast
);
    import rcfd_pkg::*;

    localparam logic [CHAN_IDX_W-1:0] LAST_CH = CHAN_IDX_W'(NUM_CHANNELS - 1);

    logic [PAYLOAD_BITS-1:0] shadow_reg, shadow_next;
    logic [CHAN_IDX_W-1:0]   ch_reg, ch_next;
    logic                    active_reg, active_next;
    logic                    valid_reg, valid_next;
    logic [CHAN_IDX_W-1:0]   idx_reg, idx_next;
    logic [CHAN_BITS-1:0]    raw_reg, raw_next;
    logic [PULSE_W-1:0]      pulse_reg, pulse_next;
    logic                    last_reg, last_next;

    logic                     out_free;
    logic                     step;
    logic [CHAN_BITS-1:0]     raw;
    logic signed [15:0]       diff;
    logic signed [15:0]       scaled;
    logic signed [15:0]       quot;
    logic signed [15:0]       us;
    logic signed [15:0]       lo_s;
    logic signed [15:0]       hi_s;

    assign out_free  = !valid_reg || m_tready;
    assign step      = active_reg && out_free;
    assign emit_busy = active_reg;

    // Convert the current channel: times 5, divide by 8 toward zero, recenter, clamp
    assign raw    = shadow_reg[CHAN_BITS-1:0];
    assign diff   = $signed({5'b0, raw}) - 16'sd992;
    assign scaled = (diff <<< 2) + diff;
    assign quot   = scaled[15] ? ((scaled + 16'sd7) >>> 3) : (scaled >>> 3);
    assign us     = quot + 16'(PULSE_MID);
    assign lo_s   = $signed({4'b0, min_pulse_us});
    assign hi_s   = $signed({4'b0, max_pulse_us});

    always_comb begin
        if (us < lo_s) begin
            pulse_next = min_pulse_us;
        end else if (us > hi_s) begin
            pulse_next = max_pulse_us;
        end else begin
            pulse_next = us[PULSE_W-1:0];
        end
    end

    // Sequence channels into the output register
    always_comb begin
        shadow_next = shadow_reg;
        ch_next     = ch_reg;
        active_next = active_reg;
        valid_next  = valid_reg;
        idx_next    = idx_reg;
        raw_next    = raw_reg;
        last_next   = last_reg;
        if (step) begin
            valid_next  = 1'b1;
            idx_next    = ch_reg;
            raw_next    = raw;
            last_next   = (ch_reg == LAST_CH);
            shadow_next = {{CHAN_BITS{1'b0}}, shadow_reg[PAYLOAD_BITS-1:CHAN_BITS]};
            ch_next     = ch_reg + 1'b1;
            if (ch_reg == LAST_CH) begin
                active_next = 1'b0;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
        // load a new frame; only arrives while idle
        if (frame_load.valid) begin
            shadow_next = frame_load.payload;
            ch_next     = '0;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            ch_reg     <= '0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            ch_reg     <= ch_next;
        end
    end

    always_ff @(posedge aclk) begin
        shadow_reg <= shadow_next;
        idx_reg    <= idx_next;
        raw_reg    <= raw_next;
        last_reg   <= last_next;
        if (step) begin
            pulse_reg <= pulse_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'b0, pulse_reg, raw_reg, idx_reg};

`ifndef NO_ASSERTIONS
    // A new frame never arrives while channels are still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_load.valid |-> !active_reg)
        else $error("frame load while emitter busy");

    // The last word of a frame carries the last channel index
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && last_reg) |-> (idx_reg == LAST_CH))
        else $error("tlast on wrong channel");

    // Channel counter stays inside the configured channel count
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (ch_reg <= LAST_CH))
        else $error("channel counter out of range");

    // Finishing the last channel ends the burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && ch_reg == LAST_CH && !frame_load.valid) |=> !active_reg)
        else $error("emitter did not stop after last channel");
`endif

endmodule

FILE: hw/rtl/rc_link_channel_frame_decoder.sv
// Top level of the RC link frame decoder: configuration registers, parser and emitter.
//
//  channel   direction  ports                         payload
//  s_        in         s_tvalid/s_tready/s_tdata     rx_byte[7:0]
//  m_        out        m_tvalid/m_tready/m_tdata     channel_index, raw_value, pulse_us
//                       m_tlast                       last_channel
//  cfg_      in         cfg_valid/cfg_ready           cfg_index[1:0], cfg_data[11:0]
//
// The parser keeps up with one received word per clock while the CRC word is not held off.
// A good frame yields NUM_CHANNELS result words, one per cycle unless m_tready stalls
// the output; the CRC word sets the active flag, which then registers the first word.
// The CRC word of the next frame is held off while the emitter still has channels left.
// aresetn is synchronous and active low; it returns the parser to the address byte
// and loads the configuration reset values. cfg_ready is always high.
module rc_link_channel_frame_decoder #(
    parameter int NUM_CHANNELS = rcfd_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_FRAME    = rcfd_pkg::MAX_FRAME_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [3:0] channel_index,
                                                       // [14:4] raw_value,
                                                       // [26:15] pulse_us, rest zero
    output logic                            m_tlast,   // last_channel
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [11:0]                     cfg_data
);
    import rcfd_pkg::*;

    logic [7:0]         frame_type_reg;
    logic [PULSE_W-1:0] min_pulse_reg;
    logic [PULSE_W-1:0] max_pulse_reg;
    logic               emit_busy;
    frame_load_t        frame_load;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_type_reg <= FRAME_TYPE_RST;
            min_pulse_reg  <= MIN_PULSE_RST;
            max_pulse_reg  <= MAX_PULSE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_TYPE: frame_type_reg <= cfg_data[7:0];
                CFG_MIN_PULSE:  min_pulse_reg  <= cfg_data;
                CFG_MAX_PULSE:  max_pulse_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    rcfd_frame_rx #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_rx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .frame_type (frame_type_reg),
        .emit_busy  (emit_busy),
        .frame_load (frame_load)
    );

    rcfd_chan_emit #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_chan_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_load   (frame_load),
        .min_pulse_us (min_pulse_reg),
        .max_pulse_us (max_pulse_reg),
        .emit_busy    (emit_busy),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the RC link channel frame decoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcfd_pkg::*;

    localparam int NUM_CH         = NUM_CHANNELS_DEF;
    localparam int FRAME_MAX      = MAX_FRAME_DEF;
    localparam int DRAIN_CYCLES   = 2 * NUM_CH + 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic [CHAN_IDX_W-1:0] chan;
        logic [CHAN_BITS-1:0]  raw;
        logic [PULSE_W-1:0]    pulse;
        logic                  is_last;
    } channel_word_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_TYPE;
    logic [11:0]          cfg_data  = 12'h000;

    // Mirror of the decoder state and configuration
    int                   rx_pos  = 0;
    int                   rx_size = 0;
    logic [7:0]           rx_kind = 8'h00;
    logic [7:0]           rx_crc  = 8'h00;
    logic [7:0]           rx_store [PAYLOAD_BYTES] = '{default: 8'h00};
    logic [7:0]           frame_type_cfg = FRAME_TYPE_RST;
    logic [PULSE_W-1:0]   min_pulse_cfg  = MIN_PULSE_RST;
    logic [PULSE_W-1:0]   max_pulse_cfg  = MAX_PULSE_RST;

    channel_word_t        pending_channels[$];
    int                   mismatches    = 0;
    int                   quiet_cycles  = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   hold_requests = 0;
    int                   words_sent    = 0;

    rc_link_channel_frame_decoder #(
        .NUM_CHANNELS(NUM_CH),
        .MAX_FRAME   (FRAME_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] rx_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [3:0] channel_index, [14:4] raw_value, [26:15] pulse_us
        .m_tlast  (m_tlast),   // last_channel
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // CRC-8 over one byte, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       msb;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            msb = c[7];
            c = {c[6:0], 1'b0};
            if (msb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Convert a raw channel value and clamp it, lower limit first
    function automatic logic [PULSE_W-1:0] pulse_of(input logic [CHAN_BITS-1:0] raw);
        int us;
        us = ((int'(raw) - PULSE_CENTER) * 5) / 8 + PULSE_MID;
        if (us < int'(min_pulse_cfg)) return min_pulse_cfg;
        if (us > int'(max_pulse_cfg)) return max_pulse_cfg;
        return us[PULSE_W-1:0];
    endfunction

    // Advance the frame parser by one received byte; queue the channels of a good frame
    function automatic void decode_rx_byte(input logic [7:0] b);
        channel_word_t           w;
        logic [PAYLOAD_BITS-1:0] bits;
        bit                      good;
        if (rx_pos == 0) begin
            rx_pos  = 1;
            rx_size = 0;
            return;
        end
        if (rx_pos == 1) begin
            if (int'(b) < 2 || int'(b) > FRAME_MAX - 2) begin
                rx_pos = 0;
                return;
            end
            rx_size = int'(b) + 2;
            rx_crc  = 8'h00;
            rx_pos  = 2;
            return;
        end
        if (rx_pos + 1 < rx_size) begin
            if (rx_pos == 2) rx_kind = b;
            else if (rx_pos - 3 < PAYLOAD_BYTES) rx_store[rx_pos - 3] = b;
            rx_crc = crc8_step(rx_crc, b);
            rx_pos++;
            return;
        end
        // crc byte closes the frame
        rx_pos  = 0;
        good    = (b == rx_crc) && (rx_kind == frame_type_cfg) &&
                  (rx_size == int'(GOOD_FRAME_SIZE));
        rx_size = 0;
        if (!good) return;
        for (int i = 0; i < PAYLOAD_BYTES; i++) bits[i*8 +: 8] = rx_store[i];
        for (int ch = 0; ch < NUM_CH && ch < 16; ch++) begin
            w.chan    = CHAN_IDX_W'(ch);
            w.raw     = bits[ch*CHAN_BITS +: CHAN_BITS];
            w.pulse   = pulse_of(w.raw);
            w.is_last = (ch + 1 == NUM_CH) || (ch == 15);
            pending_channels.push_back(w);
        end
    endfunction

    // Track every handshake, check results in order, and guard against a hang
    always @(posedge aclk) begin
        channel_word_t want;
        bit            moved;
        if (aresetn) begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_FRAME_TYPE: frame_type_cfg = cfg_data[7:0];
                    CFG_MIN_PULSE:  min_pulse_cfg  = cfg_data[PULSE_W-1:0];
                    CFG_MAX_PULSE:  max_pulse_cfg  = cfg_data[PULSE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                decode_rx_byte(s_tdata);
            end
            if (m_tvalid === 1'b1 && m_tready) begin
                moved = 1'b1;
                if (pending_channels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result word: tdata %h tlast %b", m_tdata, m_tlast);
                end else begin
                    want = pending_channels.pop_front();
                    if (m_tdata !== 32'({want.pulse, want.raw, want.chan}) ||
                        m_tlast !== want.is_last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result mismatch: chan %0d/%0d raw %0d/%0d pulse %0d/%0d %s",
                                     want.chan, m_tdata[3:0], want.raw, m_tdata[14:4],
                                     want.pulse, m_tdata[26:15],
                                     $sformatf("last %b/%b pad %h (expected/actual)",
                                               want.is_last, m_tlast, m_tdata[31:27]));
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Drive the result side: random idling, plus a long hold-off on request
    always @(negedge aclk) begin
        int hold_seen;
        int hold_left;
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one word after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    // Send address, length, type, body and crc; crc_flip corrupts the check byte
    task automatic send_frame(input logic [7:0] kind, input byte_q_t body,
                              input logic [7:0] crc_flip);
        logic [7:0] crc;
        crc = crc8_step(8'h00, kind);
        foreach (body[i]) crc = crc8_step(crc, body[i]);
        send_byte(8'($urandom_range(255)));
        send_byte(8'(body.size() + 2));
        send_byte(kind);
        foreach (body[i]) send_byte(body[i]);
        send_byte(crc ^ crc_flip);
    endtask

    function automatic byte_q_t random_body(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    // Channel values at the ends of the range and around the center
    function automatic byte_q_t extremes_body();
        logic [CHAN_BITS-1:0]    vals [8] = '{11'd0, 11'd2047, 11'd992, 11'd985,
                                              11'd1811, 11'd172, 11'd1, 11'd2046};
        logic [PAYLOAD_BITS-1:0] bits;
        byte_q_t                 q;
        for (int ch = 0; ch < 16; ch++)
            bits[ch*CHAN_BITS +: CHAN_BITS] = (ch < 8) ? vals[ch] : ((ch % 2) ? 11'h7FF : 11'h000);
        for (int i = 0; i < PAYLOAD_BYTES; i++) q.push_back(bits[i*8 +: 8]);
        return q;
    endfunction

    // Feed filler until the parser waits for an address again
    task automatic realign();
        while (rx_pos != 0) send_byte(8'($urandom_range(255)));
    endtask

    // Drop the input valid, wait for all results, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_channels.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write all three registers once the block is idle
    task automatic set_config(input logic [7:0] kind, input logic [11:0] lo, input logic [11:0] hi);
        drain();
        write_register(CFG_FRAME_TYPE, {4'h0, kind});
        write_register(CFG_MIN_PULSE, lo);
        write_register(CFG_MAX_PULSE, hi);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Good frame under the reset configuration
    task automatic test_reset_values();
        send_frame(frame_type_cfg, extremes_body(), 8'h00);
    endtask

    // Length bytes just outside the legal range, then a good frame
    task automatic test_bad_length();
        send_byte(8'h00);
        send_byte(8'd0);
        send_byte(8'hFF);
        send_byte(8'd1);
        send_byte(8'h5A);
        send_byte(8'(FRAME_MAX - 1));
        send_byte(8'hC8);
        send_byte(8'hFF);
        send_frame(frame_type_cfg, random_body(PAYLOAD_BYTES), 8'h00);
    endtask

    // Bad crc, wrong type, short and overlong payloads, then a good frame
    task automatic test_rejected_frames();
        send_frame(frame_type_cfg, random_body(PAYLOAD_BYTES), 8'h01);
        send_frame(frame_type_cfg ^ 8'h80, random_body(PAYLOAD_BYTES), 8'h00);
        send_frame(frame_type_cfg, random_body(0), 8'h00);
        send_frame(frame_type_cfg, random_body(PAYLOAD_BYTES - 1), 8'h00);
        send_frame(frame_type_cfg, random_body(FRAME_MAX - 4), 8'h00);
        send_frame(frame_type_cfg, random_body(PAYLOAD_BYTES), 8'h00);
    endtask

    // Lower limit above the upper one
    task automatic test_crossed_limits();
        set_config(FRAME_TYPE_RST, 12'd1500, 12'd1400);
        send_frame(frame_type_cfg, extremes_body(), 8'h00);
    endtask

    // Mostly good frames with random content, the rest broken frames and noise
    task automatic test_random_traffic(input int n_words);
        int start;
        int pick;
        start = words_sent;
        while (words_sent - start < n_words) begin
            realign();
            pick = $urandom_range(99);
            if (pick < 65) begin
                send_frame(frame_type_cfg, random_body(PAYLOAD_BYTES), 8'h00);
            end else if (pick < 72) begin
                send_frame(frame_type_cfg, random_body(PAYLOAD_BYTES), 8'($urandom_range(1, 255)));
            end else if (pick < 79) begin
                send_frame(frame_type_cfg ^ 8'($urandom_range(1, 255)),
                           random_body(PAYLOAD_BYTES), 8'h00);
            end else if (pick < 86) begin
                send_frame(frame_type_cfg, random_body($urandom_range(0, FRAME_MAX - 4)), 8'h00);
            end else if (pick < 93) begin
                send_byte(8'($urandom_range(255)));
                send_byte($urandom_range(1) ? 8'($urandom_range(1))
                                            : 8'($urandom_range(FRAME_MAX - 1, 255)));
            end else begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
            end
        end
        realign();
    endtask

    // Stall the result side long enough that the input backs up
    task automatic test_backpressure();
        hold_requests++;
        repeat (2) send_frame(frame_type_cfg, random_body(PAYLOAD_BYTES), 8'h00);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 14;
        recv_idle_pct = 78;
        test_reset_values();
        test_bad_length();
        test_rejected_frames();
        test_crossed_limits();
        set_config(8'h00, 12'd0, 12'd4095);
        test_random_traffic(40);

        send_idle_pct = 78;
        recv_idle_pct = 14;
        set_config(8'hFF, 12'd4095, 12'd0);
        test_random_traffic(30);
        set_config(8'hA5, 12'd1000, 12'd2000);
        test_random_traffic(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(FRAME_TYPE_RST, MIN_PULSE_RST, MAX_PULSE_RST);
        test_backpressure();
        test_random_traffic(30);

        drain();
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rcfd_pkg.sv
hw/rtl/rcfd_frame_rx.sv
hw/rtl/rcfd_chan_emit.sv
hw/rtl/rc_link_channel_frame_decoder.sv
tb/tb.sv
